// ----- rtl/utf8_text_chunk_splitter_defines.svh -----
// assertion macros for the utf8 text chunk splitter
`ifndef UTF8_TEXT_CHUNK_SPLITTER_DEFINES_SVH
`define UTF8_TEXT_CHUNK_SPLITTER_DEFINES_SVH

// checked outside reset only
`define UTCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UTCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/utcs_pkg.sv -----
// shared types and constants of the utf8 text chunk splitter
`timescale 1ns / 1ps
`default_nettype none

package utcs_pkg;

  localparam int LOOKBACK_FRACTION_DEF = 4;
  localparam int OFFSET_BITS_DEF       = 32;
  localparam int RQ_DEPTH              = 4;

  localparam logic [15:0] PART_LIMIT_RESET = 16'd32;
  localparam logic [15:0] PART_LIMIT_MIN   = 16'd32;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  typedef struct packed {
    logic [31:0] part_begin;
    logic [31:0] part_end;
    logic        closing_part;
    logic        offset_overflow;
  } utcs_result_t;

  typedef struct packed {
    logic         v0;
    logic         v1;
    utcs_result_t r0;
    utcs_result_t r1;
  } utcs_push_t;

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] lead_absorb(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      n = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      n = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/utcs_if.sv -----
// item channel interfaces of the utf8 text chunk splitter
`timescale 1ns / 1ps
`default_nettype none

interface utcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface utcs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] part_begin;
  logic [31:0] part_end;
  logic        closing_part;
  logic        offset_overflow;

  modport source (output valid, output part_begin, output part_end,
                  output closing_part, output offset_overflow, input ready);
  modport sink   (input valid, input part_begin, input part_end,
                  input closing_part, input offset_overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/utcs_track.sv -----
// code point counting and break tracking, one byte per step
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_text_chunk_splitter_defines.svh"

module utcs_track #(
  parameter int LOOKBACK_FRACTION = utcs_pkg::LOOKBACK_FRACTION_DEF,
  parameter int OFFSET_BITS       = utcs_pkg::OFFSET_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        text_byte,
  input  wire logic              final_byte,
  input  wire logic [15:0]       part_limit,
  output utcs_pkg::utcs_push_t   push
);

  localparam int OW = OFFSET_BITS;

  // reciprocal of the lookback fraction, exact for every 16-bit limit
  localparam int     LB_SHIFT = 16 + $clog2(LOOKBACK_FRACTION);
  localparam longint LB_MULT  = ((longint'(1) << LB_SHIFT) + longint'(LOOKBACK_FRACTION) - 1)
                                / longint'(LOOKBACK_FRACTION);

  logic [OW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [OW-1:0] start_r, start_nxt;
  logic [15:0]   pts_r, pts_nxt;
  logic [1:0]    absorb_r, absorb_nxt;
  logic          nl_v_r, nl_v_nxt;
  logic [15:0]   nl_pt_r, nl_pt_nxt;
  logic [OW-1:0] nl_off_r, nl_off_nxt;
  logic          sp_v_r, sp_v_nxt;
  logic [15:0]   sp_pt_r, sp_pt_nxt;
  logic [OW-1:0] sp_off_r, sp_off_nxt;
  logic          wrap_r, wrap_nxt;

  logic [OW-1:0] here;
  logic [OW-1:0] cut;
  logic [33:0]   lb_prod;
  logic [15:0]   lookback;
  logic          text_clear;

  always_comb begin
    here         = byte_cnt_r;
    byte_cnt_nxt = byte_cnt_r + 1'b1;
    wrap_nxt     = wrap_r | (byte_cnt_nxt == '0);
    start_nxt    = start_r;
    pts_nxt      = pts_r;
    absorb_nxt   = absorb_r;
    nl_v_nxt     = nl_v_r;
    nl_pt_nxt    = nl_pt_r;
    nl_off_nxt   = nl_off_r;
    sp_v_nxt     = sp_v_r;
    sp_pt_nxt    = sp_pt_r;
    sp_off_nxt   = sp_off_r;
    cut          = nl_off_r + 1'b1;
    lb_prod      = 34'(part_limit) * 34'(LB_MULT);
    lookback     = 16'(lb_prod >> LB_SHIFT);
    if (lookback == 16'd0) begin
      lookback = 16'd1;
    end
    push = '0;

    if (absorb_r != 2'd0) begin
      absorb_nxt = absorb_r - 2'd1;
    end else begin
      if (pts_r >= part_limit) begin
        push.v0                 = 1'b1;
        push.r0.part_begin      = 32'(start_r);
        push.r0.closing_part    = 1'b0;
        push.r0.offset_overflow = wrap_nxt;
        if (nl_v_r && nl_pt_r >= lookback) begin
          // newline stays in the closed part
          push.r0.part_end = 32'(cut);
          start_nxt        = cut;
          pts_nxt          = pts_r - nl_pt_r - 16'd1;
          if (sp_v_r && sp_pt_r > nl_pt_r) begin
            sp_pt_nxt = sp_pt_r - nl_pt_r - 16'd1;
          end else begin
            sp_v_nxt = 1'b0;
          end
          nl_v_nxt = 1'b0;
        end else if (sp_v_r && sp_pt_r >= lookback) begin
          // space is dropped
          push.r0.part_end = 32'(sp_off_r);
          start_nxt        = sp_off_r + 1'b1;
          pts_nxt          = pts_r - sp_pt_r - 16'd1;
          nl_v_nxt         = 1'b0;
          sp_v_nxt         = 1'b0;
        end else begin
          push.r0.part_end = 32'(here);
          start_nxt        = here;
          pts_nxt          = 16'd0;
          nl_v_nxt         = 1'b0;
          sp_v_nxt         = 1'b0;
        end
      end
      if (text_byte == utcs_pkg::CH_NEWLINE) begin
        nl_v_nxt   = 1'b1;
        nl_pt_nxt  = pts_nxt;
        nl_off_nxt = here;
      end else if (text_byte == utcs_pkg::CH_SPACE) begin
        sp_v_nxt   = 1'b1;
        sp_pt_nxt  = pts_nxt;
        sp_off_nxt = here;
      end
      pts_nxt    = pts_nxt + 16'd1;
      absorb_nxt = utcs_pkg::lead_absorb(text_byte);
    end

    if (final_byte) begin
      push.v1                 = 1'b1;
      push.r1.part_begin      = 32'(start_nxt);
      push.r1.part_end        = 32'(byte_cnt_nxt);
      push.r1.closing_part    = 1'b1;
      push.r1.offset_overflow = wrap_nxt;
      byte_cnt_nxt = '0;
      start_nxt    = '0;
      pts_nxt      = 16'd0;
      absorb_nxt   = 2'd0;
      nl_v_nxt     = 1'b0;
      nl_pt_nxt    = 16'd0;
      nl_off_nxt   = '0;
      sp_v_nxt     = 1'b0;
      sp_pt_nxt    = 16'd0;
      sp_off_nxt   = '0;
      wrap_nxt     = 1'b0;
    end

    if (!step) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      start_r    <= '0;
      pts_r      <= 16'd0;
      absorb_r   <= 2'd0;
      nl_v_r     <= 1'b0;
      nl_pt_r    <= 16'd0;
      nl_off_r   <= '0;
      sp_v_r     <= 1'b0;
      sp_pt_r    <= 16'd0;
      sp_off_r   <= '0;
      wrap_r     <= 1'b0;
    end else if (step) begin
      byte_cnt_r <= byte_cnt_nxt;
      start_r    <= start_nxt;
      pts_r      <= pts_nxt;
      absorb_r   <= absorb_nxt;
      nl_v_r     <= nl_v_nxt;
      nl_pt_r    <= nl_pt_nxt;
      nl_off_r   <= nl_off_nxt;
      sp_v_r     <= sp_v_nxt;
      sp_pt_r    <= sp_pt_nxt;
      sp_off_r   <= sp_off_nxt;
      wrap_r     <= wrap_nxt;
    end
  end

  assign text_clear = (byte_cnt_r == '0) && (pts_r == 16'd0) && (start_r == '0) && !wrap_r;

  `UTCS_ASSERT(a_final_clears, (step && final_byte) |=> text_clear, "state kept after final item")
  `UTCS_ASSERT(a_absorb_no_cut, (step && absorb_r != 2'd0) |-> !push.v0, "cut inside a code point")

endmodule

`default_nettype wire

// ----- rtl/utcs_rqueue.sv -----
// small result queue, takes up to two results a cycle and gives one while head_ready is high
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_text_chunk_splitter_defines.svh"

module utcs_rqueue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  utcs_pkg::utcs_push_t        push,
  output logic                        room2,
  output logic                        head_valid,
  input  wire logic                   head_ready,
  output utcs_pkg::utcs_result_t      head
);

  localparam int DEPTH = utcs_pkg::RQ_DEPTH;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  utcs_pkg::utcs_result_t entry_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] wr_ptr1;
  logic          pop;
  logic [1:0]    n_push;
  utcs_pkg::utcs_result_t first;

  assign room2      = (count_r <= CW'(DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
  assign first      = push.v0 ? push.r0 : push.r1;
  assign wr_ptr1    = IW'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = IW'(wr_ptr_r + n_push);
    rd_ptr_nxt = IW'(rd_ptr_r + pop);
    count_nxt  = CW'(count_r + n_push - pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0 || push.v1) begin
      entry_r[wr_ptr_r] <= first;
    end
    if (push.v0 && push.v1) begin
      entry_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `UTCS_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CW'(DEPTH), "queue count past depth")
  `UTCS_ASSERT(a_push_room, (push.v0 || push.v1) |-> room2, "push without room")

endmodule

`default_nettype wire

// ----- rtl/utf8_text_chunk_splitter.sv -----
// top level: utf8 text chunk splitter
// flow: an accepted item waits in the input item register until the tracker steps it,
//   which needs room for two results; its results go into the result queue and reach out_bus from its head
// throughput: one byte per cycle, held back only while the four-entry result queue
//   has fewer than two free slots (the queue drains one result per cycle while out_bus.ready is high)
// reset: synchronous active-low rst_n clears all trackers and the queue, part_limit goes to 32
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_text_chunk_splitter_defines.svh"

module utf8_text_chunk_splitter #(
  parameter int LOOKBACK_FRACTION = utcs_pkg::LOOKBACK_FRACTION_DEF,
  parameter int OFFSET_BITS       = utcs_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  utcs_in_if.sink          in_bus,
  utcs_out_if.source       out_bus,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  logic        s0_valid_r, s0_valid_nxt;
  logic [7:0]  s0_byte_r;
  logic        s0_final_r;
  logic [15:0] part_limit_r;
  logic        room2;
  logic        step;
  logic        in_fire;

  utcs_pkg::utcs_push_t   push;
  utcs_pkg::utcs_result_t head;

  assign step         = s0_valid_r && room2;
  assign in_bus.ready = !s0_valid_r || step;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign s0_valid_nxt = in_fire || (s0_valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      part_limit_r <= utcs_pkg::PART_LIMIT_RESET;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      if (cfg_we && cfg_data >= utcs_pkg::PART_LIMIT_MIN) begin
        part_limit_r <= cfg_data;
      end
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r  <= in_bus.text_byte;
      s0_final_r <= in_bus.final_byte;
    end
  end

  utcs_track #(
    .LOOKBACK_FRACTION (LOOKBACK_FRACTION),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .text_byte  (s0_byte_r),
    .final_byte (s0_final_r),
    .part_limit (part_limit_r),
    .push       (push)
  );

  utcs_rqueue u_rqueue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .head_valid (out_bus.valid),
    .head_ready (out_bus.ready),
    .head       (head)
  );

  assign out_bus.part_begin      = head.part_begin;
  assign out_bus.part_end        = head.part_end;
  assign out_bus.closing_part    = head.closing_part;
  assign out_bus.offset_overflow = head.offset_overflow;

  `UTCS_ASSERT(a_limit_floor, part_limit_r >= utcs_pkg::PART_LIMIT_MIN, "part limit below floor")

endmodule

`default_nettype wire
